FILE: hw/rtl/plar_pkg.sv
`default_nettype none
package plar_pkg;

  localparam int COORD_W = 32;
  localparam int NUM_W = 7;
  localparam int DIFF_W = 32;
  localparam int LEN_W = 34;
  localparam int SQ_W = 2 * LEN_W;
  localparam int MAX_OUT_POINTS = 64;
  localparam int MAX_IN_POINTS_DEF = 256;
  localparam logic [NUM_W-1:0] NUM_POINTS_RESET = NUM_W'(64);
  localparam logic [0:0] REG_NUM_POINTS = 1'b0;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } point_t;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_SQRT,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [1:0] {
    EMIT_PT,
    EMIT_FIRST,
    EMIT_LERP,
    EMIT_PAD
  } emit_kind_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_START,
    S_PT_RD,
    S_PT_CAP,
    S_SEG_CHK,
    S_RD_A,
    S_RD_B,
    S_DIFF,
    S_SQ_GO,
    S_SQ_WAIT,
    S_RT_GO,
    S_RT_WAIT,
    S_SEG_DONE,
    S_STEP_GO,
    S_STEP_WAIT,
    S_FIRST_RD,
    S_FIRST_CAP,
    S_LCHK,
    S_LM_GO,
    S_LM_WAIT,
    S_LD_GO,
    S_LD_WAIT,
    S_PAD_RD,
    S_PAD_CAP,
    S_EMIT
  } state_t;

  function automatic logic [COORD_W-1:0] axis_of(point_t p, logic [1:0] sel);
    case (sel)
      2'd0: axis_of = p.x;
      2'd1: axis_of = p.y;
      default: axis_of = p.z;
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/plar_store.sv
`default_nettype none
module plar_store #(
  parameter int DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  plar_pkg::point_t             wdata,
  input  logic [$clog2(DEPTH)-1:0]     raddr,
  output plar_pkg::point_t             rdata
);
  import plar_pkg::*;

  point_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/plar_alu.sv
`default_nettype none
module plar_alu #(
  parameter int W = 80
) (
  input  logic               clk,
  input  logic               rst,
  input  plar_pkg::alu_req_t req,
  input  logic [W-1:0]       a,
  input  logic [W-1:0]       b,
  output logic               done,
  output logic [W-1:0]       result
);
  import plar_pkg::*;

  localparam int RW = LEN_W + 4;
  localparam int ITW = $clog2(W + 1);

  logic           busy;
  alu_op_t        op;
  logic [ITW-1:0] iter;
  logic [W-1:0]   opa;
  logic [W-1:0]   opb;
  logic [W-1:0]   acc;
  logic [RW-1:0]  rrem;
  logic [RW-1:0]  sq_in;
  logic [RW-1:0]  sq_trial;
  logic [RW-1:0]  dv_in;
  logic [RW-1:0]  dv_den;

  // Square root brings down two radicand bits per step, division one.
  assign sq_in    = {rrem[RW-3:0], opa[SQ_W-1 -: 2]};
  assign sq_trial = {acc[RW-3:0], 2'b01};
  assign dv_in    = {rrem[RW-2:0], opa[W-1]};
  assign dv_den   = RW'(opb[LEN_W-1:0]);
  assign result   = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        case (req.op)
          ALU_MUL:  iter <= ITW'(DIFF_W);
          ALU_SQRT: iter <= ITW'(LEN_W);
          default:  iter <= ITW'(W);
        endcase
      end else if (busy) begin
        iter <= iter - 1'b1;
        if (iter == ITW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op   <= req.op;
      opa  <= a;
      opb  <= b;
      acc  <= '0;
      rrem <= '0;
    end else if (busy) begin
      case (op)
        ALU_MUL: begin
          if (opa[0]) begin
            acc <= acc + opb;
          end
          opa <= opa >> 1;
          opb <= opb << 1;
        end
        ALU_SQRT: begin
          opa <= opa << 2;
          if (sq_in >= sq_trial) begin
            rrem <= sq_in - sq_trial;
            acc  <= {acc[W-2:0], 1'b1};
          end else begin
            rrem <= sq_in;
            acc  <= acc << 1;
          end
        end
        default: begin
          opa <= opa << 1;
          if (dv_in >= dv_den) begin
            rrem <= dv_in - dv_den;
            acc  <= {acc[W-2:0], 1'b1};
          end else begin
            rrem <= dv_in;
            acc  <= acc << 1;
          end
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/polyline_arc_length_resampler_unit.sv
`default_nettype none
// Channel   Signals                                    Direction  Transaction
// input     px, py, pz, end_of_line                     in         in_valid & !in_stall
// output    qx, qy, qz, final_point, overflow          out        out_valid & !out_stall
// config    psel, penable, pwrite, paddr, pwdata ...   in/out     access phase with pwrite
//
// A point without end_of_line is stored if the store has room.
// A closing point starts the sequencer: the segment lengths (two passes), the step
// division and every interpolated point all use the one shared iterative unit.
// When the count already matches, stored points go out unchanged, each once the last has gone.
// Reset is synchronous; it empties the store count and sets num_points to 64.
// While a result waits under out_stall the sequencer holds; in_stall stays high until
// the last result of the line has gone.
module polyline_arc_length_resampler_unit #(
  parameter int MAX_IN_POINTS = plar_pkg::MAX_IN_POINTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic signed [31:0]  px,
  input  logic signed [31:0]  py,
  input  logic signed [31:0]  pz,
  input  logic                end_of_line,
  input  logic                in_valid,
  output logic                in_stall,
  output logic signed [31:0]  qx,
  output logic signed [31:0]  qy,
  output logic signed [31:0]  qz,
  output logic                final_point,
  output logic                overflow,
  output logic                out_valid,
  input  logic                out_stall,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import plar_pkg::*;

  localparam int AW    = $clog2(MAX_IN_POINTS);
  localparam int CW    = $clog2(MAX_IN_POINTS + 1);
  localparam int TOT_W = LEN_W + AW;
  localparam int REM_W = TOT_W + 1;
  localparam int W     = DIFF_W + REM_W;
  localparam int CMPW  = (CW > NUM_W) ? CW : NUM_W;

  state_t             state;
  state_t             state_next;
  logic [CW-1:0]      count;
  logic               ovf;
  logic [NUM_W-1:0]   num_points;
  logic [NUM_W-1:0]   n_clamp;
  logic [NUM_W-1:0]   n_eff;
  logic [CW-1:0]      last;
  logic [CW-1:0]      i;
  logic [CW-1:0]      ip1;
  logic [NUM_W-1:0]   k;
  logic               pass;
  emit_kind_t         kind;
  logic [1:0]         j;
  point_t             pa;
  point_t             pb;
  logic [DIFF_W-1:0]  d [3];
  logic [2:0]         ge;
  logic [SQ_W-1:0]    sumsq;
  logic [LEN_W-1:0]   len;
  logic [TOT_W-1:0]   total;
  logic [TOT_W-1:0]   step;
  logic [REM_W-1:0]   rem;
  logic [W-1:0]       prod;
  logic [31:0]        ox;
  logic [31:0]        oy;
  logic [31:0]        oz;
  logic [31:0]        lerp_val;

  logic               in_acc;
  logic               out_acc;
  logic               store_we;
  point_t             store_wdata;
  logic [AW-1:0]      raddr;
  point_t             rdata;
  alu_req_t           alu_req;
  logic [W-1:0]       alu_a;
  logic [W-1:0]       alu_b;
  logic               alu_done;
  logic [W-1:0]       alu_res;
  logic               cfg_wr;

  // Configuration register: a single word at byte address zero.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_NUM_POINTS);
  assign prdata = (paddr[2] == REG_NUM_POINTS) ? 32'(num_points) : '0;

  // Out-of-range point counts fold to the nearest legal one.
  always_comb begin
    if (num_points == '0) begin
      n_clamp = NUM_W'(1);
    end else if (num_points > NUM_W'(MAX_OUT_POINTS)) begin
      n_clamp = NUM_W'(MAX_OUT_POINTS);
    end else begin
      n_clamp = num_points;
    end
  end

  assign in_stall    = (state != S_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign out_valid   = (state == S_EMIT);
  assign out_acc     = out_valid && !out_stall;
  assign final_point = (k == n_eff - NUM_W'(1));
  assign overflow    = ovf;
  assign qx          = ox;
  assign qy          = oy;
  assign qz          = oz;
  assign ip1         = i + CW'(1);

  // Points past the store are dropped, only the overflow flag records them.
  assign store_we    = in_acc && (count != CW'(MAX_IN_POINTS));
  assign store_wdata = '{x: px, y: py, z: pz};

  plar_store #(.DEPTH(MAX_IN_POINTS)) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (count[AW-1:0]),
    .wdata (store_wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  plar_alu #(.W(W)) u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .a      (alu_a),
    .b      (alu_b),
    .done   (alu_done),
    .result (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer, if the stored count differs: the first pass sums the segment lengths, the second
  // walks them again and places a point each time the carried remainder reaches the step.
  always_comb begin
    state_next    = state;
    alu_req.start = 1'b0;
    alu_req.op    = ALU_MUL;
    alu_a         = W'(d[j]);
    alu_b         = W'(d[j]);
    raddr         = i[AW-1:0];
    case (state)
      S_IDLE: begin
        if (in_acc && end_of_line) begin
          state_next = S_START;
        end
      end
      S_START: begin
        if (CMPW'(count) == CMPW'(n_clamp)) begin
          state_next = S_PT_RD;
        end else begin
          state_next = S_SEG_CHK;
        end
      end
      S_PT_RD: begin
        raddr      = AW'(k);
        state_next = S_PT_CAP;
      end
      S_PT_CAP: state_next = S_EMIT;
      S_SEG_CHK: begin
        if (i < last) begin
          state_next = S_RD_A;
        end else if (pass) begin
          state_next = S_PAD_RD;
        end else if (n_eff > NUM_W'(1)) begin
          state_next = S_STEP_GO;
        end else begin
          state_next = S_FIRST_RD;
        end
      end
      S_RD_A: begin
        raddr      = i[AW-1:0];
        state_next = S_RD_B;
      end
      S_RD_B: begin
        raddr      = ip1[AW-1:0];
        state_next = S_DIFF;
      end
      S_DIFF: state_next = S_SQ_GO;
      S_SQ_GO: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_MUL;
        state_next    = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        if (alu_done) begin
          state_next = (j == 2'd2) ? S_RT_GO : S_SQ_GO;
        end
      end
      S_RT_GO: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_SQRT;
        alu_a         = W'(sumsq);
        state_next    = S_RT_WAIT;
      end
      S_RT_WAIT: begin
        if (alu_done) begin
          state_next = S_SEG_DONE;
        end
      end
      S_SEG_DONE: begin
        if (pass && (len != '0)) begin
          state_next = S_LCHK;
        end else begin
          state_next = S_SEG_CHK;
        end
      end
      S_STEP_GO: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_DIV;
        alu_a         = W'(total);
        alu_b         = W'(n_eff - NUM_W'(1));
        state_next    = S_STEP_WAIT;
      end
      S_STEP_WAIT: begin
        if (alu_done) begin
          state_next = S_FIRST_RD;
        end
      end
      S_FIRST_RD: begin
        raddr      = '0;
        state_next = S_FIRST_CAP;
      end
      S_FIRST_CAP: state_next = S_EMIT;
      S_LCHK: begin
        state_next = (rem >= REM_W'(step)) ? S_LM_GO : S_SEG_CHK;
      end
      S_LM_GO: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_MUL;
        alu_b         = W'(rem);
        state_next    = S_LM_WAIT;
      end
      S_LM_WAIT: begin
        if (alu_done) begin
          state_next = S_LD_GO;
        end
      end
      S_LD_GO: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_DIV;
        alu_a         = prod;
        alu_b         = W'(len);
        state_next    = S_LD_WAIT;
      end
      S_LD_WAIT: begin
        if (alu_done) begin
          state_next = (j == 2'd2) ? S_EMIT : S_LM_GO;
        end
      end
      S_PAD_RD: begin
        raddr      = last[AW-1:0];
        state_next = S_PAD_CAP;
      end
      S_PAD_CAP: state_next = S_EMIT;
      S_EMIT: begin
        if (out_acc) begin
          if (final_point) begin
            state_next = S_IDLE;
          end else begin
            case (kind)
              EMIT_PT:    state_next = S_PT_RD;
              EMIT_FIRST: state_next = S_SEG_CHK;
              EMIT_LERP:  state_next = S_LCHK;
              default:    state_next = S_EMIT;
            endcase
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      ovf        <= 1'b0;
      num_points <= NUM_POINTS_RESET;
    end else begin
      if (cfg_wr) begin
        num_points <= pwdata[NUM_W-1:0];
      end
      if (in_acc) begin
        if (store_we) begin
          count <= count + CW'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (out_acc && final_point) begin
        count <= '0;
        ovf   <= 1'b0;
      end
    end
  end

  // A new point sits between a and b: b moved toward a by |a - b| * rem / len.
  assign lerp_val = ge[j] ? (axis_of(pb, j) + alu_res[31:0])
                          : (axis_of(pb, j) - alu_res[31:0]);

  always_ff @(posedge clk) begin
    case (state)
      S_START: begin
        n_eff <= n_clamp;
        last  <= count - CW'(1);
        i     <= '0;
        k     <= '0;
        pass  <= 1'b0;
        total <= '0;
      end
      S_PT_CAP: begin
        ox   <= rdata.x;
        oy   <= rdata.y;
        oz   <= rdata.z;
        kind <= EMIT_PT;
      end
      S_RD_B: pa <= rdata;
      S_DIFF: begin
        pb    <= rdata;
        j     <= '0;
        sumsq <= '0;
        for (int t = 0; t < 3; t++) begin
          ge[t] <= $signed(axis_of(pa, 2'(t))) >= $signed(axis_of(rdata, 2'(t)));
          if ($signed(axis_of(pa, 2'(t))) >= $signed(axis_of(rdata, 2'(t)))) begin
            d[t] <= axis_of(pa, 2'(t)) - axis_of(rdata, 2'(t));
          end else begin
            d[t] <= axis_of(rdata, 2'(t)) - axis_of(pa, 2'(t));
          end
        end
      end
      S_SQ_WAIT: begin
        if (alu_done) begin
          sumsq <= sumsq + alu_res[SQ_W-1:0];
          j     <= j + 2'd1;
        end
      end
      S_RT_WAIT: begin
        if (alu_done) begin
          len <= alu_res[LEN_W-1:0];
        end
      end
      S_SEG_DONE: begin
        if (!pass) begin
          total <= total + TOT_W'(len);
          i     <= ip1;
        end else if (len == '0) begin
          i <= ip1;
        end else begin
          rem <= rem + REM_W'(len);
        end
      end
      S_STEP_WAIT: begin
        if (alu_done) begin
          step <= alu_res[TOT_W-1:0];
        end
      end
      S_FIRST_CAP: begin
        ox   <= rdata.x;
        oy   <= rdata.y;
        oz   <= rdata.z;
        kind <= EMIT_FIRST;
        pass <= 1'b1;
        i    <= '0;
        rem  <= '0;
      end
      S_LCHK: begin
        if (rem >= REM_W'(step)) begin
          rem <= rem - REM_W'(step);
          j   <= '0;
        end else begin
          i <= ip1;
        end
      end
      S_LM_WAIT: begin
        if (alu_done) begin
          prod <= alu_res;
        end
      end
      S_LD_WAIT: begin
        if (alu_done) begin
          case (j)
            2'd0:    ox <= lerp_val;
            2'd1:    oy <= lerp_val;
            default: oz <= lerp_val;
          endcase
          j    <= j + 2'd1;
          kind <= EMIT_LERP;
        end
      end
      S_PAD_CAP: begin
        ox   <= rdata.x;
        oy   <= rdata.y;
        oz   <= rdata.z;
        kind <= EMIT_PAD;
      end
      S_EMIT: begin
        if (out_acc) begin
          k <= k + NUM_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // The result index never reaches the output point count of the line.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> (k < n_eff))
    else $error("result index beyond point count");

  // Taking the last result of a line empties the store and reopens the input.
  assert property (@(posedge clk) disable iff (rst)
    (out_acc && final_point) |=> ((count == '0) && !in_stall))
    else $error("line not closed after final result");

  // The shared unit reports completion only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    alu_done |-> (state == S_SQ_WAIT || state == S_RT_WAIT || state == S_STEP_WAIT ||
                  state == S_LM_WAIT || state == S_LD_WAIT))
    else $error("arithmetic unit finished outside a wait state");

endmodule
`default_nettype wire
